// ===== hw/rtl/sea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sea_pkg
// shared types, codes and constants of the software event arbiter
// ----------------------------------------------------------------------------
package sea_pkg;

    localparam int NUM_EVENTS_DEF = 8;
    localparam int SLOT_W = 3;
    localparam int MASK_W = 8;
    localparam logic [63:0] PRIO_MAX = 64'h0000_0000_ffff_ffff;

    typedef enum logic [3:0] {
        OP_REGISTER   = 4'd0,
        OP_UNREGISTER = 4'd1,
        OP_ENABLE     = 4'd2,
        OP_DISABLE    = 4'd3,
        OP_RAISE      = 4'd4,
        OP_INJECT     = 4'd5,
        OP_SET_PRIO   = 4'd6,
        OP_SET_CFG    = 4'd7,
        OP_MASK       = 4'd8,
        OP_UNMASK     = 4'd9,
        OP_PROCESS    = 4'd10,
        OP_COMPLETE   = 4'd11,
        OP_READ       = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        RC_OK              = 3'd0,
        RC_NOT_SUPPORTED   = 3'd1,
        RC_INVALID_PARAM   = 3'd2,
        RC_INVALID_STATE   = 3'd3,
        RC_ALREADY_STARTED = 3'd4,
        RC_ALREADY_STOPPED = 3'd5,
        RC_NOTHING_RUNNING = 3'd6
    } rc_t;

    typedef enum logic [1:0] {
        ST_UNUSED     = 2'd0,
        ST_REGISTERED = 2'd1,
        ST_ENABLED    = 2'd2,
        ST_RUNNING    = 2'd3
    } est_t;

    localparam logic [1:0] REG_AVAIL = 2'd0;
    localparam logic [1:0] REG_INJ   = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture request, clear scan
        logic scan;   // visit one slot
        logic exec;   // commit the operation
    } sea_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } sea_sts_t;

    typedef struct packed {
        rc_t         status;
        logic        taken;
        logic        delivered;
        logic [2:0]  event_slot;
        logic [63:0] deliv_pc;
        logic [63:0] deliv_arg;
        logic [3:0]  status_word;
    } sea_res_t;

endpackage

// ===== hw/rtl/sea_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sea_ctrl
// sequencer: load request, scan slots, execute, hold result
// ----------------------------------------------------------------------------
module sea_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            out_fire,
    input  sea_pkg::sea_sts_t sts,
    output sea_pkg::sea_cmd_t cmd,
    output logic            in_ready,
    output logic            out_valid
);
    import sea_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } fsm_t;

    fsm_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = in_fire;
                if (in_fire) state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_fire) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_exec_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> out_valid) else $error("exec without result");
    a_load_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.scan) else $error("load without scan");
endmodule

// ===== hw/rtl/sea_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sea_dp
// event slot table, ranking scan and operation execution
// ----------------------------------------------------------------------------
module sea_dp #(
    parameter int NUM_EVENTS = sea_pkg::NUM_EVENTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sea_pkg::sea_cmd_t cmd,
    output sea_pkg::sea_sts_t sts,
    input  logic [3:0]        in_op,
    input  logic [2:0]        in_slot,
    input  logic [63:0]       in_value,
    input  logic [63:0]       in_arg,
    input  logic              in_allowed,
    input  logic [7:0]        avail_mask,
    input  logic [7:0]        inj_mask,
    output sea_pkg::sea_res_t res
);
    import sea_pkg::*;

    localparam int IW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int CW = $clog2(NUM_EVENTS + 1);

    est_t        st_reg   [NUM_EVENTS];
    logic [NUM_EVENTS-1:0] pend_reg, once_reg;
    logic [31:0] prio_reg [NUM_EVENTS];
    logic [63:0] pc_reg   [NUM_EVENTS];
    logic [63:0] arg_reg  [NUM_EVENTS];
    logic        unmask_reg, kick_reg;

    logic [3:0]  op_reg;
    logic [2:0]  slot_reg;
    logic [63:0] value_reg, harg_reg;
    logic        allowed_reg;

    logic [CW-1:0] idx_reg;
    logic          nx_v_reg, run_v_reg;
    logic [IW-1:0] nx_reg, run_reg;
    logic [31:0]   nx_p_reg, run_p_reg;
    sea_res_t      res_reg;
    sea_res_t      res_next;

    function automatic logic in_op_is_slot(input logic [3:0] op);
        return (op <= 4'(OP_SET_CFG)) || (op == 4'(OP_READ));
    endfunction

    logic [IW-1:0] ci;
    assign ci = idx_reg[IW-1:0];
    assign sts.scan_last = (idx_reg == CW'(NUM_EVENTS - 1));

    logic sc_nx, sc_run;
    always_comb begin
        // ties keep the earlier slot since scan ascends
        sc_nx  = (st_reg[ci] == ST_ENABLED) && pend_reg[ci] &&
                 (!nx_v_reg || prio_reg[ci] < nx_p_reg);
        sc_run = (st_reg[ci] == ST_RUNNING) &&
                 (!run_v_reg || prio_reg[ci] < run_p_reg);
    end

    logic [IW-1:0] s;
    logic present, inj, nx_wins;
    est_t cst;
    always_comb begin
        s = IW'(slot_reg);
        present = (32'(slot_reg) < NUM_EVENTS) && avail_mask[slot_reg];
        inj = inj_mask[slot_reg];
        cst = (32'(slot_reg) < NUM_EVENTS) ? st_reg[s] : ST_UNUSED;
        nx_wins = nx_v_reg && unmask_reg &&
                  (!run_v_reg || nx_p_reg < run_p_reg ||
                   (nx_p_reg == run_p_reg && nx_reg < run_reg));
    end

    // response of the captured request
    always_comb begin
        res_next = '0;
        res_next.status = RC_OK;
        if (in_op_is_slot(op_reg) && !present) begin
            res_next.status = RC_NOT_SUPPORTED;
        end else begin
            unique case (op_reg)
                OP_REGISTER: begin
                    if (value_reg[0] || !allowed_reg)
                        res_next.status = RC_INVALID_PARAM;
                    else if (cst != ST_UNUSED)
                        res_next.status = RC_INVALID_STATE;
                end
                OP_UNREGISTER: begin
                    if (cst != ST_REGISTERED) res_next.status = RC_INVALID_STATE;
                end
                OP_ENABLE: begin
                    if (cst != ST_REGISTERED) res_next.status = RC_INVALID_STATE;
                end
                OP_DISABLE: begin
                    if (cst != ST_ENABLED) res_next.status = RC_INVALID_STATE;
                end
                OP_RAISE: begin
                    res_next.taken = unmask_reg &&
                        (cst == ST_ENABLED || cst == ST_RUNNING);
                end
                OP_INJECT: begin
                    if (!inj) res_next.status = RC_INVALID_PARAM;
                end
                OP_SET_PRIO: begin
                    if (value_reg > PRIO_MAX) res_next.status = RC_INVALID_PARAM;
                    else if (cst == ST_ENABLED || cst == ST_RUNNING)
                        res_next.status = RC_INVALID_STATE;
                end
                OP_SET_CFG: begin
                    if (value_reg[63:1] != '0) res_next.status = RC_INVALID_PARAM;
                    else if (cst == ST_ENABLED || cst == ST_RUNNING)
                        res_next.status = RC_INVALID_STATE;
                end
                OP_MASK: begin
                    if (!unmask_reg) res_next.status = RC_ALREADY_STOPPED;
                end
                OP_UNMASK: begin
                    if (unmask_reg) res_next.status = RC_ALREADY_STARTED;
                end
                OP_PROCESS: begin
                    if (kick_reg && nx_wins) begin
                        res_next.delivered = 1'b1;
                        res_next.event_slot = 3'(nx_reg);
                        res_next.deliv_pc = pc_reg[nx_reg];
                        res_next.deliv_arg = arg_reg[nx_reg];
                    end
                end
                OP_COMPLETE: begin
                    if (!run_v_reg) res_next.status = RC_NOTHING_RUNNING;
                    else res_next.event_slot = 3'(run_reg);
                end
                OP_READ: begin
                    res_next.status_word = {inj, pend_reg[s], cst};
                end
                default: res_next.status = RC_NOT_SUPPORTED;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op; slot_reg <= in_slot; value_reg <= in_value;
            harg_reg <= in_arg; allowed_reg <= in_allowed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_EVENTS; i++) begin
                st_reg[i] <= ST_UNUSED; prio_reg[i] <= '0;
                pc_reg[i] <= '0; arg_reg[i] <= '0;
            end
            pend_reg <= '0; once_reg <= '0;
            unmask_reg <= 1'b0; kick_reg <= 1'b0;
            idx_reg <= '0; nx_v_reg <= 1'b0; run_v_reg <= 1'b0;
        end else if (cmd.load) begin
            idx_reg <= '0; nx_v_reg <= 1'b0; run_v_reg <= 1'b0;
        end else if (cmd.scan) begin
            if (sc_nx) begin
                nx_v_reg <= 1'b1; nx_reg <= ci; nx_p_reg <= prio_reg[ci];
            end
            if (sc_run) begin
                run_v_reg <= 1'b1; run_reg <= ci; run_p_reg <= prio_reg[ci];
            end
            if (!sts.scan_last) idx_reg <= idx_reg + 1'b1;
        end else if (cmd.exec) begin
            res_reg <= res_next;
            if (res_next.status == RC_OK) begin
                unique case (op_reg)
                    OP_REGISTER: begin
                        pc_reg[s] <= value_reg; arg_reg[s] <= harg_reg;
                        st_reg[s] <= ST_REGISTERED;
                    end
                    OP_UNREGISTER: begin
                        st_reg[s] <= ST_UNUSED; pend_reg[s] <= 1'b0;
                        prio_reg[s] <= '0; once_reg[s] <= 1'b0;
                        pc_reg[s] <= '0; arg_reg[s] <= '0;
                    end
                    OP_ENABLE: begin
                        st_reg[s] <= ST_ENABLED;
                        if (pend_reg[s]) kick_reg <= 1'b1;
                    end
                    OP_DISABLE: st_reg[s] <= ST_REGISTERED;
                    OP_RAISE: begin
                        if (cst != ST_UNUSED) begin
                            pend_reg[s] <= 1'b1; kick_reg <= 1'b1;
                        end
                    end
                    OP_INJECT: begin
                        pend_reg[s] <= 1'b1; kick_reg <= 1'b1;
                    end
                    OP_SET_PRIO: prio_reg[s] <= value_reg[31:0];
                    OP_SET_CFG: once_reg[s] <= value_reg[0];
                    OP_MASK: unmask_reg <= 1'b0;
                    OP_UNMASK: begin
                        unmask_reg <= 1'b1; kick_reg <= 1'b1;
                    end
                    OP_PROCESS: begin
                        if (kick_reg && !nx_v_reg) kick_reg <= 1'b0;
                        if (res_next.delivered) begin
                            pend_reg[nx_reg] <= 1'b0;
                            st_reg[nx_reg] <= ST_RUNNING;
                        end
                    end
                    OP_COMPLETE: begin
                        st_reg[run_reg] <= once_reg[run_reg] ? ST_REGISTERED
                                                             : ST_ENABLED;
                        kick_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign res = res_reg;

    a_nx_en: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && nx_v_reg |-> st_reg[nx_reg] == ST_ENABLED && pend_reg[nx_reg])
        else $error("next candidate not pending enabled");
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && run_v_reg |-> st_reg[run_reg] == ST_RUNNING)
        else $error("running candidate not running");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg < CW'(NUM_EVENTS)) else $error("scan index out of range");
endmodule

// ===== hw/rtl/software_event_arbiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_event_arbiter_top
// single-hart supervisor software event controller with apb config
// ----------------------------------------------------------------------------
// a request is accepted only in idle; all slots are scanned, the operation
// executes and the result is held until taken before the next is accepted
// the scan visits one slot per cycle for every operation
// reset: synchronous active-low aresetn clears all slots, mask and kick
// after reset available_mask is 0xff and injectable_mask 0xc0
module software_event_arbiter_top #(
    parameter int NUM_EVENTS = sea_pkg::NUM_EVENTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[3:0], slot[6:4], value[70:7], handler_arg[134:71],
    // entry_allowed[135]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], taken[3], delivered[4], event_slot[7:5], deliv_pc[71:8],
    // deliv_arg[135:72], status_word[139:136], zero fill to 143
    output logic [143:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sea_pkg::*;

    sea_cmd_t cmd;
    sea_sts_t sts;
    sea_res_t res;
    logic [7:0] avail_reg, inj_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avail_reg <= 8'hff;
            inj_reg   <= 8'hc0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_INJ[0]) inj_reg <= pwdata[7:0];
            else avail_reg <= pwdata[7:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_INJ[0]) prdata[7:0] = inj_reg;
        else prdata[7:0] = avail_reg;
    end

    sea_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
        .sts(sts), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    sea_dp #(.NUM_EVENTS(NUM_EVENTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_op(s_tdata[3:0]), .in_slot(s_tdata[6:4]),
        .in_value(s_tdata[70:7]), .in_arg(s_tdata[134:71]),
        .in_allowed(s_tdata[135]),
        .avail_mask(avail_reg), .inj_mask(inj_reg), .res(res)
    );

    assign m_tdata = {4'b0, res.status_word, res.deliv_arg, res.deliv_pc,
                      res.event_slot, res.delivered, res.taken, res.status};
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software event arbiter testbench
// drives event requests and apb register writes into the arbiter, predicts
// each response with a cycle-free model of the slot table and compares the
// responses field by field in order
// ----------------------------------------------------------------------------
module tb;
    import sea_pkg::*;

    class event_scoreboard;
        logic [7:0]  avail_mask;
        logic [7:0]  inj_mask;
        est_t        slot_st [8];
        logic        pend [8];
        logic [31:0] prio [8];
        logic        oneshot [8];
        logic [63:0] pc [8];
        logic [63:0] arg [8];
        logic        unmasked;
        logic        kick;
        sea_res_t    pending_q [$];
        int          errors;

        function new();
            avail_mask = 8'hff;
            inj_mask = 8'hc0;
            unmasked = 1'b0;
            kick = 1'b0;
            errors = 0;
            for (int i = 0; i < 8; i++) clear_slot(i);
        endfunction

        function void clear_slot(int s);
            slot_st[s] = ST_UNUSED;
            pend[s] = 1'b0;
            prio[s] = '0;
            oneshot[s] = 1'b0;
            pc[s] = '0;
            arg[s] = '0;
        endfunction

        function bit outranks(int a, int b);
            if (prio[a] != prio[b]) return prio[a] < prio[b];
            return a < b;
        endfunction

        function int top_slot(est_t st);
            int best;
            best = -1;
            for (int i = 0; i < 8; i++) begin
                if (slot_st[i] != st) continue;
                if (st == ST_ENABLED && !pend[i]) continue;
                if (best < 0 || outranks(i, best)) best = i;
            end
            return best;
        endfunction

        function rc_t move(int s, est_t from, est_t to);
            if (slot_st[s] != from) return RC_INVALID_STATE;
            slot_st[s] = to;
            if (to == ST_ENABLED && pend[s]) kick = 1'b1;
            if (to == ST_UNUSED) clear_slot(s);
            return RC_OK;
        endfunction

        function void note_request(logic [3:0] op, int s, logic [63:0] val,
                                   logic [63:0] harg, logic allowed);
            sea_res_t r;
            int nx;
            int run;
            r = '0;
            r.status = RC_OK;
            if ((op <= OP_SET_CFG || op == OP_READ) && !avail_mask[s]) begin
                r.status = RC_NOT_SUPPORTED;
            end else begin
                case (op)
                    OP_REGISTER: begin
                        if (val[0] || !allowed) r.status = RC_INVALID_PARAM;
                        else if (slot_st[s] != ST_UNUSED) r.status = RC_INVALID_STATE;
                        else begin
                            pc[s] = val;
                            arg[s] = harg;
                            slot_st[s] = ST_REGISTERED;
                        end
                    end
                    OP_UNREGISTER: r.status = move(s, ST_REGISTERED, ST_UNUSED);
                    OP_ENABLE: r.status = move(s, ST_REGISTERED, ST_ENABLED);
                    OP_DISABLE: r.status = move(s, ST_ENABLED, ST_REGISTERED);
                    OP_RAISE: begin
                        r.taken = unmasked && slot_st[s] >= ST_ENABLED;
                        if (slot_st[s] != ST_UNUSED) begin
                            pend[s] = 1'b1;
                            kick = 1'b1;
                        end
                    end
                    OP_INJECT: begin
                        if (!inj_mask[s]) r.status = RC_INVALID_PARAM;
                        else begin
                            pend[s] = 1'b1;
                            kick = 1'b1;
                        end
                    end
                    OP_SET_PRIO: begin
                        if (val > PRIO_MAX) r.status = RC_INVALID_PARAM;
                        else if (slot_st[s] >= ST_ENABLED) r.status = RC_INVALID_STATE;
                        else prio[s] = val[31:0];
                    end
                    OP_SET_CFG: begin
                        if (val[63:1] != '0) r.status = RC_INVALID_PARAM;
                        else if (slot_st[s] >= ST_ENABLED) r.status = RC_INVALID_STATE;
                        else oneshot[s] = val[0];
                    end
                    OP_MASK: begin
                        if (!unmasked) r.status = RC_ALREADY_STOPPED;
                        else unmasked = 1'b0;
                    end
                    OP_UNMASK: begin
                        if (unmasked) r.status = RC_ALREADY_STARTED;
                        else begin
                            unmasked = 1'b1;
                            kick = 1'b1;
                        end
                    end
                    OP_PROCESS: begin
                        if (kick) begin
                            nx = top_slot(ST_ENABLED);
                            if (nx < 0) kick = 1'b0;
                            run = top_slot(ST_RUNNING);
                            if (nx >= 0 && unmasked && (run < 0 || outranks(nx, run))) begin
                                r.delivered = 1'b1;
                                r.event_slot = nx[2:0];
                                r.deliv_pc = pc[nx];
                                r.deliv_arg = arg[nx];
                                pend[nx] = 1'b0;
                                slot_st[nx] = ST_RUNNING;
                            end
                        end
                    end
                    OP_COMPLETE: begin
                        run = top_slot(ST_RUNNING);
                        if (run < 0) r.status = RC_NOTHING_RUNNING;
                        else begin
                            r.event_slot = run[2:0];
                            slot_st[run] = oneshot[run] ? ST_REGISTERED : ST_ENABLED;
                            kick = 1'b1;
                        end
                    end
                    OP_READ: r.status_word = {inj_mask[s], pend[s], slot_st[s]};
                    default: r.status = RC_NOT_SUPPORTED;
                endcase
            end
            pending_q.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_response(logic [143:0] d);
            sea_res_t w;
            if (pending_q.size() == 0) begin
                report("unexpected response", d[63:0], 0);
                return;
            end
            w = pending_q.pop_front();
            if (d[2:0] != w.status) report("status", d[2:0], w.status);
            if (d[3] != w.taken) report("taken", d[3], w.taken);
            if (d[4] != w.delivered) report("delivered", d[4], w.delivered);
            if (d[7:5] != w.event_slot) report("event_slot", d[7:5], w.event_slot);
            if (d[71:8] != w.deliv_pc) report("deliv_pc", d[71:8], w.deliv_pc);
            if (d[135:72] != w.deliv_arg) report("deliv_arg", d[135:72], w.deliv_arg);
            if (d[139:136] != w.status_word)
                report("status_word", d[139:136], w.status_word);
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    event_scoreboard events_sb;
    bit   sink_idle_on = 1'b1;
    bit   src_idle_on = 1'b1;
    int   quiet_cycles = 0;

    software_event_arbiter_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // response sink with random stall bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) events_sb.check_response(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 4000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(logic [3:0] op, logic [2:0] s, logic [63:0] val,
                                logic [63:0] harg, logic allowed);
        int n;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {allowed, harg, val, s, op};
        do @(posedge aclk); while (!s_tready);
        events_sb.note_request(op, s, val, harg, allowed);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (events_sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 1'b0} << 1;
        pwdata <= {8'($urandom_range(0, 255)), 16'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_AVAIL) events_sb.avail_mask = val;
        else events_sb.inj_mask = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_request(bit well_formed);
        logic [3:0]  op;
        logic [2:0]  s;
        logic [63:0] val;
        s = 3'($urandom_range(0, 7));
        op = 4'($urandom_range(0, 15));
        val = rand64();
        if (well_formed) begin
            op = 4'($urandom_range(0, 12));
            case ($urandom_range(0, 9))
                0, 1, 2: op = $urandom_range(0, 1) ? OP_PROCESS : OP_COMPLETE;
                3: op = OP_RAISE;
                default: ;
            endcase
            if (op == OP_REGISTER) val[0] = 1'b0;
            if (op == OP_SET_PRIO && $urandom_range(0, 3) != 0)
                val = $urandom_range(0, 3) == 0 ? {32'h0, $urandom}
                                                : 64'($urandom_range(0, 5));
            if (op == OP_SET_CFG && $urandom_range(0, 3) != 0)
                val = 64'($urandom_range(0, 1));
        end
        send_request(op, s, val, rand64(), well_formed ? ($urandom_range(0, 7) != 0)
                                                        : 1'($urandom_range(0, 1)));
    endtask

    initial begin
        events_sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: masked hart, edges of fields, every operation except unregister, undefined opcodes
        send_request(OP_MASK, 0, 0, 0, 1);
        send_request(OP_REGISTER, 0, 64'hffff_ffff_ffff_fffe, '1, 1);
        send_request(OP_REGISTER, 1, 64'h1, 0, 1);
        send_request(OP_REGISTER, 1, 64'h2, 0, 0);
        send_request(OP_REGISTER, 0, 64'h4, 0, 1);
        send_request(OP_SET_PRIO, 0, 64'h1_0000_0000, 0, 1);
        send_request(OP_SET_PRIO, 0, PRIO_MAX, 0, 1);
        send_request(OP_SET_CFG, 0, 64'h2, 0, 1);
        send_request(OP_SET_CFG, 0, 64'h1, 0, 1);
        send_request(OP_REGISTER, 7, 64'h0, 64'h5a, 1);
        send_request(OP_RAISE, 7, 0, 0, 1);
        send_request(OP_RAISE, 3, 0, 0, 1);
        send_request(OP_INJECT, 2, 0, 0, 1);
        send_request(OP_INJECT, 6, 0, 0, 1);
        send_request(OP_ENABLE, 0, 0, 0, 1);
        send_request(OP_ENABLE, 7, 0, 0, 1);
        send_request(OP_PROCESS, 0, 0, 0, 1);
        send_request(OP_UNMASK, 0, 0, 0, 1);
        send_request(OP_UNMASK, 0, 0, 0, 1);
        send_request(OP_RAISE, 0, 0, 0, 1);
        send_request(OP_PROCESS, 0, 0, 0, 1);
        send_request(OP_PROCESS, 0, 0, 0, 1);
        send_request(OP_COMPLETE, 0, 0, 0, 1);
        send_request(OP_COMPLETE, 0, 0, 0, 1);
        send_request(OP_DISABLE, 7, 0, 0, 1);
        send_request(OP_READ, 7, 0, 0, 1);
        send_request(4'd13, 0, 0, 0, 1);
        send_request(4'd15, 0, 0, 0, 1);

        write_reg(REG_AVAIL, 8'h00);
        send_request(OP_READ, 3, 0, 0, 1);
        send_request(OP_RAISE, 5, 0, 0, 1);
        write_reg(REG_AVAIL, 8'hff);
        write_reg(REG_INJ, 8'hff);

        for (int i = 0; i < 640; i++) begin
            if (i == 200) begin
                write_reg(REG_AVAIL, 8'h7f);
                write_reg(REG_INJ, 8'h00);
            end
            if (i == 400) begin
                write_reg(REG_AVAIL, 8'hff);
                write_reg(REG_INJ, 8'hc0);
            end
            if (i == 500) begin
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
            end
            random_request($urandom_range(0, 9) != 0);
        end

        drain();
        if (events_sb.errors == 0 && events_sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
